// File: rtl/owtr_pkg.sv
// Shared types, constants and helpers for the 1-Wire temperature reader.
// Used by owtr_seq, owtr_skid and one_wire_temp_sensor_reader.
// No dependencies.
package owtr_pkg;

    // The sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_REL,
        PH_PRES_WAIT,
        PH_PRES_LOW,
        PH_WR_LOW,
        PH_WR_REL,
        PH_RD_LOW,
        PH_RD_WAIT,
        PH_RD_REC
    } t_phase;

    // Configuration register indexes, in address order.
    typedef enum logic [2:0] {
        REG_RESET_LOW,
        REG_RESET_RELEASE,
        REG_PRES_WAIT,
        REG_PRES_LOW,
        REG_SHORT_LOW,
        REG_LONG_SLOT,
        REG_READ_SAMPLE,
        REG_READ_RECOVERY
    } t_reg_idx;

    typedef struct packed {
        logic [9:0] reset_low_ticks;
        logic [5:0] reset_release_ticks;
        logic [7:0] presence_wait_limit;
        logic [7:0] presence_low_limit;
        logic [3:0] short_low_ticks;
        logic [6:0] long_slot_ticks;
        logic [3:0] read_sample_ticks;
        logic [6:0] read_recovery_ticks;
    } t_cfg;

    typedef struct packed {
        logic               pull_low;
        logic               busy_res;
        logic               done_res;
        logic               presence_error;
        logic signed [15:0] raw_reading;
        logic signed [11:0] whole_degrees;
    } t_result;

    localparam logic [9:0] RESET_LOW_DEFAULT     = 10'd750;
    localparam logic [5:0] RESET_RELEASE_DEFAULT = 6'd15;
    localparam logic [7:0] PRES_WAIT_DEFAULT     = 8'd200;
    localparam logic [7:0] PRES_LOW_DEFAULT      = 8'd240;
    localparam logic [3:0] SHORT_LOW_DEFAULT     = 4'd2;
    localparam logic [6:0] LONG_SLOT_DEFAULT     = 7'd60;
    localparam logic [3:0] READ_SAMPLE_DEFAULT   = 4'd12;
    localparam logic [6:0] READ_RECOVERY_DEFAULT = 7'd50;

    // Skip ROM, convert, skip ROM, read scratchpad.
    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;
    localparam logic [7:0] CMD_READ_SPAD = 8'hBE;

    function automatic logic cmd_bit(input logic [1:0] byte_idx, input logic [2:0] bit_idx);
        logic [7:0] cmd;
        case (byte_idx)
            2'd1:    cmd = CMD_CONVERT;
            2'd3:    cmd = CMD_READ_SPAD;
            default: cmd = CMD_SKIP_ROM;
        endcase
        return cmd[bit_idx];
    endfunction

endpackage

// File: rtl/owtr_seq.sv
// Bus sequencer of the 1-Wire temperature reader: phase, slot timer and
// bit/byte counters, advanced by one tick per accepted request.
// Depends on owtr_pkg.
module owtr_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_start_req,
    input  logic             i_line_level,
    input  owtr_pkg::t_cfg    i_cfg,
    output owtr_pkg::t_result o_res
);

    owtr_pkg::t_phase r_phase, n_phase;
    logic [9:0]       r_timer, n_timer;
    logic [2:0]       r_bit_idx, n_bit_idx;
    logic [1:0]       r_byte_idx, n_byte_idx;
    logic [7:0]       r_shift, n_shift;
    logic [7:0]       r_low_byte, n_low_byte;
    logic             r_error, n_error;
    logic [15:0]      r_hold, n_hold;

    logic             w_start;
    owtr_pkg::t_phase w_phase;
    logic [9:0]       w_timer;
    logic [9:0]       w_inc;
    logic             w_cur_bit;
    logic             w_pull;
    logic             w_done;
    logic [7:0]       w_shift_in;
    logic signed [16:0] w_adj;

    // A start request in idle already counts as the first reset-low tick.
    assign w_start   = (r_phase == owtr_pkg::PH_IDLE) && i_start_req;
    assign w_phase   = w_start ? owtr_pkg::PH_RST_LOW : r_phase;
    assign w_timer   = w_start ? 10'd0 : r_timer;
    assign w_inc     = w_timer + 10'd1;
    assign w_cur_bit = owtr_pkg::cmd_bit(r_byte_idx, r_bit_idx);
    assign w_shift_in = {i_line_level, r_shift[7:1]};

    always_comb begin
        n_phase    = w_phase;
        n_timer    = w_timer;
        n_bit_idx  = w_start ? 3'd0 : r_bit_idx;
        n_byte_idx = w_start ? 2'd0 : r_byte_idx;
        n_shift    = r_shift;
        n_low_byte = r_low_byte;
        n_error    = w_start ? 1'b0 : r_error;
        n_hold     = r_hold;
        w_pull     = 1'b0;
        w_done     = 1'b0;
        unique case (w_phase)
            owtr_pkg::PH_IDLE: begin
            end
            owtr_pkg::PH_RST_LOW: begin
                w_pull = 1'b1;
                if (w_inc >= i_cfg.reset_low_ticks) begin
                    n_timer = '0;
                    n_phase = owtr_pkg::PH_RST_REL;
                end else begin
                    n_timer = w_inc;
                end
            end
            owtr_pkg::PH_RST_REL: begin
                if (w_inc >= 10'(i_cfg.reset_release_ticks)) begin
                    n_timer = '0;
                    n_phase = owtr_pkg::PH_PRES_WAIT;
                end else begin
                    n_timer = w_inc;
                end
            end
            owtr_pkg::PH_PRES_WAIT: begin
                if (!i_line_level) begin
                    n_timer = '0;
                    n_phase = owtr_pkg::PH_PRES_LOW;
                end else if (w_inc >= 10'(i_cfg.presence_wait_limit)) begin
                    n_timer   = '0;
                    n_error   = 1'b1;
                    n_phase   = owtr_pkg::PH_WR_LOW;
                    n_bit_idx = '0;
                end else begin
                    n_timer = w_inc;
                end
            end
            owtr_pkg::PH_PRES_LOW: begin
                if (i_line_level) begin
                    n_timer   = '0;
                    n_phase   = owtr_pkg::PH_WR_LOW;
                    n_bit_idx = '0;
                end else if (w_inc >= 10'(i_cfg.presence_low_limit)) begin
                    n_timer   = '0;
                    n_error   = 1'b1;
                    n_phase   = owtr_pkg::PH_WR_LOW;
                    n_bit_idx = '0;
                end else begin
                    n_timer = w_inc;
                end
            end
            owtr_pkg::PH_WR_LOW: begin
                w_pull = 1'b1;
                if (w_inc >= (w_cur_bit ? 10'(i_cfg.short_low_ticks)
                                        : 10'(i_cfg.long_slot_ticks))) begin
                    n_timer = '0;
                    n_phase = owtr_pkg::PH_WR_REL;
                end else begin
                    n_timer = w_inc;
                end
            end
            owtr_pkg::PH_WR_REL: begin
                if (w_inc >= (w_cur_bit ? 10'(i_cfg.long_slot_ticks)
                                        : 10'(i_cfg.short_low_ticks))) begin
                    n_timer   = '0;
                    n_bit_idx = r_bit_idx + 3'd1;
                    n_phase   = owtr_pkg::PH_WR_LOW;
                    if (r_bit_idx == 3'd7) begin
                        n_byte_idx = r_byte_idx + 2'd1;
                        // After the convert byte the second transaction
                        // starts with a fresh bus reset; after the read
                        // command the two data bytes are read.
                        if (r_byte_idx == 2'd1) begin
                            n_phase = owtr_pkg::PH_RST_LOW;
                        end else if (r_byte_idx == 2'd3) begin
                            n_phase = owtr_pkg::PH_RD_LOW;
                            n_shift = '0;
                        end
                    end
                end else begin
                    n_timer = w_inc;
                end
            end
            owtr_pkg::PH_RD_LOW: begin
                w_pull = 1'b1;
                if (w_inc >= 10'(i_cfg.short_low_ticks)) begin
                    n_timer = '0;
                    n_phase = owtr_pkg::PH_RD_WAIT;
                end else begin
                    n_timer = w_inc;
                end
            end
            owtr_pkg::PH_RD_WAIT: begin
                if (w_inc >= 10'(i_cfg.read_sample_ticks)) begin
                    n_timer = '0;
                    n_phase = owtr_pkg::PH_RD_REC;
                end else begin
                    n_timer = w_inc;
                end
            end
            owtr_pkg::PH_RD_REC: begin
                // The line is sampled on the first recovery tick, LSB first.
                if (w_timer == 10'd0) begin
                    n_shift = w_shift_in;
                end
                if (w_inc >= 10'(i_cfg.read_recovery_ticks)) begin
                    n_timer   = '0;
                    n_bit_idx = r_bit_idx + 3'd1;
                    n_phase   = owtr_pkg::PH_RD_LOW;
                    if (r_bit_idx == 3'd7) begin
                        if (r_byte_idx == 2'd0) begin
                            n_low_byte = n_shift;
                            n_byte_idx = 2'd1;
                            n_shift    = '0;
                        end else begin
                            n_hold     = {n_shift, r_low_byte};
                            n_byte_idx = 2'd0;
                            n_phase    = owtr_pkg::PH_IDLE;
                            w_done     = 1'b1;
                        end
                    end
                end else begin
                    n_timer = w_inc;
                end
            end
            default: begin
                n_phase = owtr_pkg::PH_IDLE;
            end
        endcase
    end

    // Truncation toward zero: bias negative readings by 15 before the shift.
    assign w_adj = $signed({n_hold[15], n_hold}) + (n_hold[15] ? 17'sd15 : 17'sd0);

    always_comb begin
        o_res.pull_low       = w_pull;
        o_res.busy_res       = (n_phase != owtr_pkg::PH_IDLE);
        o_res.done_res       = w_done;
        o_res.presence_error = n_error;
        o_res.raw_reading    = $signed(n_hold);
        o_res.whole_degrees  = w_adj[15:4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= owtr_pkg::PH_IDLE;
            r_timer    <= '0;
            r_bit_idx  <= '0;
            r_byte_idx <= '0;
            r_shift    <= '0;
            r_low_byte <= '0;
            r_error    <= 1'b0;
            r_hold     <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_timer    <= n_timer;
            r_bit_idx  <= n_bit_idx;
            r_byte_idx <= n_byte_idx;
            r_shift    <= n_shift;
            r_low_byte <= n_low_byte;
            r_error    <= n_error;
            r_hold     <= n_hold;
        end
    end

`ifndef ASSERT_OFF
    a_pull_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.pull_low |-> o_res.busy_res)
        else $error("line driven low while the sequence ends");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.done_res) |=> (r_phase == owtr_pkg::PH_IDLE))
        else $error("sequencer not idle after a finished reading");
    a_idle_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == owtr_pkg::PH_IDLE) |-> (r_bit_idx == 3'd0 && r_byte_idx == 2'd0))
        else $error("bit or byte counter left over in idle");
`endif

endmodule

// File: rtl/owtr_skid.sv
// Output register with a skid stage for the 1-Wire temperature reader, so
// that requests are still taken while a result waits at the output.
// Depends on owtr_pkg.
module owtr_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  owtr_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output owtr_pkg::t_result o_data
);

    logic              r_main_valid;
    logic              r_skid_valid;
    owtr_pkg::t_result r_main;
    owtr_pkg::t_result r_skid;
    logic              w_fire;
    logic              w_main_free;

    assign o_ready     = !r_skid_valid;
    assign w_fire      = i_valid && !r_skid_valid;
    assign w_main_free = !r_main_valid || i_ready;
    assign o_valid     = r_main_valid;
    assign o_data      = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_main_free) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= w_fire;
            end
        end else if (w_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_main_free) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end
        if (!w_main_free && w_fire) begin
            r_skid <= i_data;
        end
    end

`ifndef ASSERT_OFF
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid stage holds a result ahead of the output register");
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_valid && !i_ready && w_fire) |=> r_skid_valid)
        else $error("request taken during a stall was not kept");
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_main_valid && !r_skid_valid))
        else $error("skid stage did not move into the output register");
`endif

endmodule

// File: rtl/one_wire_temp_sensor_reader.sv
// 1-Wire bus master that reads a temperature sensor, one tick per request.
// Depends on owtr_pkg, owtr_seq and owtr_skid.
//
// Usage: every request on the input channel (i_in_valid / o_in_ready) is one
// bus tick of about 1 us, carrying the start request and the line level
// sampled in that tick. A start in idle runs two transactions: bus reset,
// presence check, skip ROM and convert; then bus reset, presence check, skip
// ROM, read scratchpad and two data bytes read LSB first. A missing presence
// pulse sets the error flag but the sequence carries on.
// Each request yields exactly one result on the output channel
// (o_out_valid / i_out_ready): the pull-low drive for that tick, busy, done,
// the presence error flag, the signed reading in sixteenths of a degree and
// whole degrees truncated toward zero. The reading holds its last value
// between measurements.
// The result is registered in the output register. One request is taken
// every cycle: the sequencer updates in a single pass per tick, and the
// output register with its skid stage keeps taking requests while the
// receiver stalls, until the skid stage is full; then o_in_ready drops.
// Reset (synchronous, active low) puts the sequencer in idle, clears the
// reading and loads the default timing values into the APB registers.
// The timing registers are written through the APB port at byte addresses
// 4*i and must only be changed while the block is idle.
module one_wire_temp_sensor_reader (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Tick requests
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_start_req,
    input  logic               i_line_level,
    // Results
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_pull_low,
    output logic               o_busy_res,
    output logic               o_done_res,
    output logic               o_presence_error,
    output logic signed [15:0] o_raw_reading,
    output logic signed [11:0] o_whole_degrees
);

    owtr_pkg::t_cfg     r_cfg;
    owtr_pkg::t_reg_idx w_reg_idx;
    owtr_pkg::t_result  w_seq_res;
    owtr_pkg::t_result  w_out_res;
    logic               w_cfg_write;
    logic               w_in_fire;

    assign pready      = 1'b1;
    assign w_reg_idx   = owtr_pkg::t_reg_idx'(paddr[4:2]);
    assign w_cfg_write = psel && penable && pwrite;
    assign w_in_fire   = i_in_valid && o_in_ready;

    // The timing registers; a write keeps only the register's own width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks     <= owtr_pkg::RESET_LOW_DEFAULT;
            r_cfg.reset_release_ticks <= owtr_pkg::RESET_RELEASE_DEFAULT;
            r_cfg.presence_wait_limit <= owtr_pkg::PRES_WAIT_DEFAULT;
            r_cfg.presence_low_limit  <= owtr_pkg::PRES_LOW_DEFAULT;
            r_cfg.short_low_ticks     <= owtr_pkg::SHORT_LOW_DEFAULT;
            r_cfg.long_slot_ticks     <= owtr_pkg::LONG_SLOT_DEFAULT;
            r_cfg.read_sample_ticks   <= owtr_pkg::READ_SAMPLE_DEFAULT;
            r_cfg.read_recovery_ticks <= owtr_pkg::READ_RECOVERY_DEFAULT;
        end else if (w_cfg_write) begin
            unique case (w_reg_idx)
                owtr_pkg::REG_RESET_LOW:     r_cfg.reset_low_ticks     <= pwdata[9:0];
                owtr_pkg::REG_RESET_RELEASE: r_cfg.reset_release_ticks <= pwdata[5:0];
                owtr_pkg::REG_PRES_WAIT:     r_cfg.presence_wait_limit <= pwdata[7:0];
                owtr_pkg::REG_PRES_LOW:      r_cfg.presence_low_limit  <= pwdata[7:0];
                owtr_pkg::REG_SHORT_LOW:     r_cfg.short_low_ticks     <= pwdata[3:0];
                owtr_pkg::REG_LONG_SLOT:     r_cfg.long_slot_ticks     <= pwdata[6:0];
                owtr_pkg::REG_READ_SAMPLE:   r_cfg.read_sample_ticks   <= pwdata[3:0];
                owtr_pkg::REG_READ_RECOVERY: r_cfg.read_recovery_ticks <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back, zero-extended to the bus width.
    always_comb begin
        unique case (w_reg_idx)
            owtr_pkg::REG_RESET_LOW:     prdata = 32'(r_cfg.reset_low_ticks);
            owtr_pkg::REG_RESET_RELEASE: prdata = 32'(r_cfg.reset_release_ticks);
            owtr_pkg::REG_PRES_WAIT:     prdata = 32'(r_cfg.presence_wait_limit);
            owtr_pkg::REG_PRES_LOW:      prdata = 32'(r_cfg.presence_low_limit);
            owtr_pkg::REG_SHORT_LOW:     prdata = 32'(r_cfg.short_low_ticks);
            owtr_pkg::REG_LONG_SLOT:     prdata = 32'(r_cfg.long_slot_ticks);
            owtr_pkg::REG_READ_SAMPLE:   prdata = 32'(r_cfg.read_sample_ticks);
            owtr_pkg::REG_READ_RECOVERY: prdata = 32'(r_cfg.read_recovery_ticks);
            default:                     prdata = '0;
        endcase
    end

    // The sequencer advances only on an accepted request.
    owtr_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_in_fire),
        .i_start_req  (i_start_req),
        .i_line_level (i_line_level),
        .i_cfg        (r_cfg),
        .o_res        (w_seq_res)
    );

    owtr_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (w_seq_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_out_res)
    );

    assign o_pull_low       = w_out_res.pull_low;
    assign o_busy_res       = w_out_res.busy_res;
    assign o_done_res       = w_out_res.done_res;
    assign o_presence_error = w_out_res.presence_error;
    assign o_raw_reading    = w_out_res.raw_reading;
    assign o_whole_degrees  = w_out_res.whole_degrees;

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_busy_res)
        else $error("done reported while the sequence is still running");
    a_whole_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_raw_reading[15] == o_whole_degrees[11]
                         || o_whole_degrees == 12'sd0))
        else $error("whole degrees disagree in sign with the reading");
    a_cfg_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cfg_write |=> $stable(r_cfg))
        else $error("timing register changed without a write");
`endif

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the 1-Wire temperature sensor reader.
// Drives bus ticks from an emulated sensor, predicts every per-tick output and compares.
// Depends on owtr_pkg and one_wire_temp_sensor_reader.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 40_000;
    localparam int PRINT_LIMIT = 200;

    // The four command bytes in the order the sequencer sends them, byte 0 lowest.
    localparam logic [31:0] BUS_CMDS = {owtr_pkg::CMD_READ_SPAD, owtr_pkg::CMD_SKIP_ROM,
                                        owtr_pkg::CMD_CONVERT, owtr_pkg::CMD_SKIP_ROM};

    // How the emulated sensor answers the presence check of one measurement.
    typedef enum logic [1:0] {
        PRES_PROMPT,
        PRES_SLOW,
        PRES_ABSENT,
        PRES_STUCK
    } t_pres_mode;

    // One bus tick request: the start request and the sampled line level.
    typedef struct packed {
        logic start;
        logic line;
    } t_tick_req;

    // Sequencer state as the testbench tracks it.
    typedef struct packed {
        owtr_pkg::t_phase phase;
        logic [9:0]       slot_tmr;
        logic [2:0]       bit_n;
        logic [1:0]       byte_n;
        logic [7:0]       shift_b;
        logic [7:0]       low_b;
        logic             pres_err;
        logic [15:0]      reading;
    } t_bus_state;

    // Clock, reset and block inputs, all known from time zero.
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [4:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic        i_in_valid   = 1'b0;
    logic        i_start_req  = 1'b0;
    logic        i_line_level = 1'b0;
    logic        i_out_ready  = 1'b0;

    logic [31:0]        prdata;
    logic               pready;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_pull_low;
    logic               o_busy_res;
    logic               o_done_res;
    logic               o_presence_error;
    logic signed [15:0] o_raw_reading;
    logic signed [11:0] o_whole_degrees;

    // Tick requests waiting to be driven, and the outputs still due from the block.
    t_tick_req          pending_ticks[$];
    owtr_pkg::t_result  due_outputs[$];

    // Two copies of the sequencer state: one runs ahead with the generator so that the
    // emulated sensor knows which slot it is in, the other follows accepted requests.
    t_bus_state     seq_gen;
    t_bus_state     seq_chk;
    owtr_pkg::t_cfg cfg_now;

    // Handshake and bookkeeping shared between the processes.
    logic              tick_taken = 1'b0;
    t_tick_req         drv_next;
    owtr_pkg::t_result want;
    int        burst_left = 0;
    int        gap_left   = 0;
    int        rx_cycle   = 0;
    int        rx_hold    = 0;
    int        rx_n_holds = 0;
    int        rx_mode    = 0;
    int        cycle_n    = 0;
    int        n_mismatch = 0;
    int        n_ticks    = 0;
    int        n_readings = 0;
    int        n_pres_err = 0;
    int        n_settings = 0;

    one_wire_temp_sensor_reader DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_start_req      (i_start_req),
        .i_line_level     (i_line_level),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_pull_low       (o_pull_low),
        .o_busy_res       (o_busy_res),
        .o_done_res       (o_done_res),
        .o_presence_error (o_presence_error),
        .o_raw_reading    (o_raw_reading),
        .o_whole_degrees  (o_whole_degrees)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Advances the slot timer by one tick. A step of zero length still lasts one tick,
    // which falls out of comparing after the increment.
    function automatic logic slot_elapsed(inout t_bus_state s, input logic [9:0] dur);
        s.slot_tmr = s.slot_tmr + 10'd1;
        if (s.slot_tmr >= dur) begin
            s.slot_tmr = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Predicts the outputs of one bus tick and moves the sequencer state on.
    function automatic owtr_pkg::t_result bus_master_tick(inout t_bus_state s,
                                                          input owtr_pkg::t_cfg c,
                                                          input logic start,
                                                          input logic line);
        owtr_pkg::t_result r;
        logic              wbit;
        int                deg;
        r = '0;
        // A start is only taken in idle; the start tick is already the first reset-low tick.
        if (s.phase == owtr_pkg::PH_IDLE && start) begin
            s.phase    = owtr_pkg::PH_RST_LOW;
            s.slot_tmr = '0;
            s.pres_err = 1'b0;
            s.byte_n   = '0;
            s.bit_n    = '0;
        end
        wbit = BUS_CMDS[{s.byte_n, s.bit_n}];
        case (s.phase)
            owtr_pkg::PH_RST_LOW: begin
                r.pull_low = 1'b1;
                if (slot_elapsed(s, c.reset_low_ticks)) s.phase = owtr_pkg::PH_RST_REL;
            end
            owtr_pkg::PH_RST_REL: begin
                if (slot_elapsed(s, 10'(c.reset_release_ticks))) begin
                    s.phase = owtr_pkg::PH_PRES_WAIT;
                end
            end
            owtr_pkg::PH_PRES_WAIT: begin
                if (!line) begin
                    s.phase    = owtr_pkg::PH_PRES_LOW;
                    s.slot_tmr = '0;
                end else if (slot_elapsed(s, 10'(c.presence_wait_limit))) begin
                    // No presence pulse: flag it and send the commands anyway.
                    s.pres_err = 1'b1;
                    s.phase    = owtr_pkg::PH_WR_LOW;
                    s.bit_n    = '0;
                    s.slot_tmr = '0;
                end
            end
            owtr_pkg::PH_PRES_LOW: begin
                if (line) begin
                    s.phase    = owtr_pkg::PH_WR_LOW;
                    s.bit_n    = '0;
                    s.slot_tmr = '0;
                end else if (slot_elapsed(s, 10'(c.presence_low_limit))) begin
                    s.pres_err = 1'b1;
                    s.phase    = owtr_pkg::PH_WR_LOW;
                    s.bit_n    = '0;
                    s.slot_tmr = '0;
                end
            end
            owtr_pkg::PH_WR_LOW: begin
                r.pull_low = 1'b1;
                if (slot_elapsed(s, wbit ? 10'(c.short_low_ticks)
                                         : 10'(c.long_slot_ticks))) begin
                    s.phase = owtr_pkg::PH_WR_REL;
                end
            end
            owtr_pkg::PH_WR_REL: begin
                if (slot_elapsed(s, wbit ? 10'(c.long_slot_ticks)
                                         : 10'(c.short_low_ticks))) begin
                    s.bit_n = s.bit_n + 3'd1;
                    s.phase = owtr_pkg::PH_WR_LOW;
                    if (s.bit_n == 3'd0) begin
                        s.byte_n = s.byte_n + 2'd1;
                        // After convert comes the second bus reset, after read scratchpad
                        // the read slots.
                        if (s.byte_n == 2'd2) begin
                            s.phase = owtr_pkg::PH_RST_LOW;
                        end else if (s.byte_n == 2'd0) begin
                            s.phase   = owtr_pkg::PH_RD_LOW;
                            s.shift_b = '0;
                        end
                    end
                end
            end
            owtr_pkg::PH_RD_LOW: begin
                r.pull_low = 1'b1;
                if (slot_elapsed(s, 10'(c.short_low_ticks))) s.phase = owtr_pkg::PH_RD_WAIT;
            end
            owtr_pkg::PH_RD_WAIT: begin
                if (slot_elapsed(s, 10'(c.read_sample_ticks))) s.phase = owtr_pkg::PH_RD_REC;
            end
            owtr_pkg::PH_RD_REC: begin
                // The line is sampled on the first recovery tick, LSB first.
                if (s.slot_tmr == 10'd0) s.shift_b = {line, s.shift_b[7:1]};
                if (slot_elapsed(s, 10'(c.read_recovery_ticks))) begin
                    s.bit_n = s.bit_n + 3'd1;
                    s.phase = owtr_pkg::PH_RD_LOW;
                    if (s.bit_n == 3'd0) begin
                        if (s.byte_n == 2'd0) begin
                            s.low_b   = s.shift_b;
                            s.byte_n  = 2'd1;
                            s.shift_b = '0;
                        end else begin
                            s.reading   = {s.shift_b, s.low_b};
                            s.byte_n    = 2'd0;
                            s.phase     = owtr_pkg::PH_IDLE;
                            r.done_res  = 1'b1;
                        end
                    end
                end
            end
            default: s.phase = owtr_pkg::PH_IDLE;
        endcase
        r.busy_res       = (s.phase != owtr_pkg::PH_IDLE);
        r.presence_error = s.pres_err;
        r.raw_reading    = s.reading;
        // Whole degrees truncate toward zero, so negative readings are scaled as magnitudes.
        deg = int'($signed(s.reading));
        if (deg < 0) deg = -((-deg) >>> 4);
        else deg = deg >>> 4;
        r.whole_degrees = deg[11:0];
        return r;
    endfunction

    function automatic owtr_pkg::t_cfg make_timing(input int rst_low, input int rst_rel,
                                                   input int pres_wait, input int pres_low,
                                                   input int short_low, input int long_slot,
                                                   input int rd_sample,
                                                   input int rd_recovery);
        owtr_pkg::t_cfg c;
        c.reset_low_ticks     = 10'(rst_low);
        c.reset_release_ticks = 6'(rst_rel);
        c.presence_wait_limit = 8'(pres_wait);
        c.presence_low_limit  = 8'(pres_low);
        c.short_low_ticks     = 4'(short_low);
        c.long_slot_ticks     = 7'(long_slot);
        c.read_sample_ticks   = 4'(rd_sample);
        c.read_recovery_ticks = 7'(rd_recovery);
        return c;
    endfunction

    // Waits until every request has been driven, accepted and answered.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || i_in_valid || due_outputs.size() != 0);
    endtask

    // One APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(input owtr_pkg::t_reg_idx idx, input int unsigned value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reprograms every timing register once the block has gone idle and been drained.
    task automatic set_timing(input owtr_pkg::t_cfg c);
        wait_drained();
        apb_write(owtr_pkg::REG_RESET_LOW,     32'(c.reset_low_ticks));
        apb_write(owtr_pkg::REG_RESET_RELEASE, 32'(c.reset_release_ticks));
        apb_write(owtr_pkg::REG_PRES_WAIT,     32'(c.presence_wait_limit));
        apb_write(owtr_pkg::REG_PRES_LOW,      32'(c.presence_low_limit));
        apb_write(owtr_pkg::REG_SHORT_LOW,     32'(c.short_low_ticks));
        apb_write(owtr_pkg::REG_LONG_SLOT,     32'(c.long_slot_ticks));
        apb_write(owtr_pkg::REG_READ_SAMPLE,   32'(c.read_sample_ticks));
        apb_write(owtr_pkg::REG_READ_RECOVERY, 32'(c.read_recovery_ticks));
        cfg_now = c;
        n_settings++;
    endtask

    task automatic queue_tick(input logic start, input logic line, output logic done);
        t_tick_req         req;
        owtr_pkg::t_result res;
        req.start = start;
        req.line  = line;
        res = bus_master_tick(seq_gen, cfg_now, start, line);
        pending_ticks.push_back(req);
        done = res.done_res;
    endtask

    // Queues one full measurement. The emulated sensor answers the presence check as the
    // mode says, returns the temperature bits in the read slots and leaves noise elsewhere.
    // Further starts are thrown in while busy; the block must ignore them.
    task automatic queue_measurement(input logic [15:0] temp, input t_pres_mode mode);
        logic start;
        logic line;
        logic done;
        repeat ($urandom_range(1, 6)) queue_tick(1'b0, 1'($urandom_range(0, 1)), done);
        do begin
            start = (seq_gen.phase == owtr_pkg::PH_IDLE) ? 1'b1
                                                         : ($urandom_range(0, 7) == 0);
            line  = 1'($urandom_range(0, 1));
            case (seq_gen.phase)
                owtr_pkg::PH_PRES_WAIT: begin
                    case (mode)
                        PRES_ABSENT: line = 1'b1;
                        PRES_SLOW:   line = ($urandom_range(0, 15) != 0);
                        default:     line = 1'($urandom_range(0, 1));
                    endcase
                end
                owtr_pkg::PH_PRES_LOW: begin
                    line = (mode == PRES_STUCK) ? 1'b0 : ($urandom_range(0, 3) == 0);
                end
                owtr_pkg::PH_RD_REC: begin
                    if (seq_gen.slot_tmr == 10'd0) begin
                        line = temp[{seq_gen.byte_n[0], seq_gen.bit_n}];
                    end
                end
                default: ;
            endcase
            queue_tick(start, line, done);
        end while (!done);
    endtask

    // Sender: requests go out in bursts of random length with random gaps between them.
    // A request stays on the bus unchanged until it is accepted.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || tick_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
                drv_next = pending_ticks.pop_front();
                i_in_valid   <= 1'b1;
                i_start_req  <= drv_next.start;
                i_line_level <= drv_next.line;
                if (burst_left <= 1) begin
                    // Now and then a long burst, and now and then no gap at all.
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                            : $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: rx_mode picks one of four stall patterns. Twice the receiver holds off
    // while plenty of requests are still queued, so that the block fills up and has
    // to refuse requests.
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 512 == 0) rx_mode = $urandom_range(0, 3);
        if (rx_hold == 0 && rx_n_holds < 2 && rx_cycle >= 100 + 300 * rx_n_holds
            && pending_ticks.size() > 40) begin
            rx_hold = 60;
            rx_n_holds++;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= ($urandom_range(0, 3) != 0);
                2:       i_out_ready <= (rx_cycle % 5 != 0);
                default: i_out_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    task automatic compare_field(input string what, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            n_mismatch++;
            // Printing stops after a while so that a broken build does not flood the log.
            if (n_mismatch <= PRINT_LIMIT) begin
                $display("%0t: %s expected %0d, got %0d", $time, what, exp_val, act_val);
            end
        end
    endtask

    // Monitor: at each rising edge an accepted request is run through the predictor and
    // an accepted output is checked against the oldest prediction. Both are handled in
    // this one process, so their order within the edge is fixed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_taken = 1'b0;
        end else begin
            tick_taken = i_in_valid && o_in_ready;
            if (tick_taken) begin
                due_outputs.push_back(bus_master_tick(seq_chk, cfg_now, i_start_req,
                                                      i_line_level));
                n_ticks++;
            end
            if (o_out_valid && i_out_ready) begin
                if (due_outputs.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= PRINT_LIMIT) begin
                        $display("%0t: output accepted with no request outstanding", $time);
                    end
                end else begin
                    want = due_outputs.pop_front();
                    compare_field("pull_low", int'(want.pull_low), int'(o_pull_low));
                    compare_field("busy_res", int'(want.busy_res), int'(o_busy_res));
                    compare_field("done_res", int'(want.done_res), int'(o_done_res));
                    compare_field("presence_error", int'(want.presence_error),
                                  int'(o_presence_error));
                    compare_field("raw_reading", int'(want.raw_reading),
                                  int'(o_raw_reading));
                    compare_field("whole_degrees", int'(want.whole_degrees),
                                  int'(o_whole_degrees));
                    if (want.done_res) begin
                        n_readings++;
                        if (want.presence_error) n_pres_err++;
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d outputs still due", cycle_n,
                     due_outputs.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus: reset, directed measurements with every duration zero and with short
    // timings, then measurements with random short timings, temperatures and presence
    // behaviour.
    initial begin
        logic [15:0] temp;
        int          deg16;
        logic        done;
        seq_gen = '0;
        seq_chk = '0;
        cfg_now = make_timing(int'(owtr_pkg::RESET_LOW_DEFAULT),
                              int'(owtr_pkg::RESET_RELEASE_DEFAULT),
                              int'(owtr_pkg::PRES_WAIT_DEFAULT),
                              int'(owtr_pkg::PRES_LOW_DEFAULT),
                              int'(owtr_pkg::SHORT_LOW_DEFAULT),
                              int'(owtr_pkg::LONG_SLOT_DEFAULT),
                              int'(owtr_pkg::READ_SAMPLE_DEFAULT),
                              int'(owtr_pkg::READ_RECOVERY_DEFAULT));
        n_settings = 1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle ticks with the line at both levels.
        queue_tick(1'b0, 1'b0, done);
        queue_tick(1'b0, 1'b1, done);

        // Every duration zero, which acts as one tick: a small negative reading (which
        // must truncate to zero degrees) with no sensor answering.
        set_timing(make_timing(0, 0, 0, 0, 0, 0, 0, 0));
        queue_measurement(16'hFFF1, PRES_ABSENT);

        // Short timings: the extremes of the reading, a prompt and a stuck sensor.
        set_timing(make_timing(3, 1, 2, 2, 1, 3, 1, 1));
        queue_measurement(16'h8000, PRES_PROMPT);
        // Queueing pauses here until every output has come back.
        wait_drained();
        queue_measurement(16'h7FFF, PRES_STUCK);

        // Random short timings, zero included, so that each measurement stays cheap.
        repeat (2) begin
            set_timing(make_timing($urandom_range(0, 12), $urandom_range(0, 4),
                                   $urandom_range(0, 8), $urandom_range(0, 8),
                                   $urandom_range(0, 3), $urandom_range(0, 6),
                                   $urandom_range(0, 3), $urandom_range(0, 4)));
            if ($urandom_range(0, 1) == 1) begin
                temp = 16'($urandom_range(0, 65535));
            end else begin
                // A plausible sensor reading between -55 and 125 degrees.
                deg16 = $urandom_range(0, 2880) - 880;
                temp  = deg16[15:0];
            end
            queue_measurement(temp, t_pres_mode'($urandom_range(0, 3)));
            if ($urandom_range(0, 1) == 1) wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d bus ticks under %0d timing settings: %0d temperature readings,",
                 n_ticks, n_settings, n_readings);
        $display("%0d of them with a presence timeout, through bursty input and stalled output.",
                 n_pres_err);
        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
